// ----- rtl/core/cbca_pkg.sv -----
// shared types and constants for the cluster box / centroid accumulator
// no dependencies; used by every module under rtl/core
package cbca_pkg;

  localparam int MAX_POINTS_DEF  = 65536;
  localparam int COORD_BITS_DEF  = 20;
  localparam int COUNT_OUT_W     = 17;
  localparam int NUM_AXES        = 3;

  // sequencer states
  typedef enum logic [1:0] {
    ST_ACC    = 2'd0,
    ST_LAUNCH = 2'd1,
    ST_WAIT   = 2'd2,
    ST_OUT    = 2'd3
  } cbca_state_t;

  // axis currently owned by the shared divider
  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } cbca_axis_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic       in_ready;
    logic       acc_clear;
    logic       div_start;
    logic       load_out;
    cbca_axis_t axis;
  } cbca_ctrl_t;

endpackage

// ----- rtl/core/cbca_accum.sv -----
// per-axis running min, max, sum and saturating point count
// depends on cbca_pkg
module cbca_accum #(
  parameter int COORD_BITS = cbca_pkg::COORD_BITS_DEF,
  parameter int MAX_POINTS = cbca_pkg::MAX_POINTS_DEF,
  parameter int CNT_W      = 17,
  parameter int SUM_W      = 36
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic                         clear,
  input  logic signed [COORD_BITS-1:0] pt [cbca_pkg::NUM_AXES],
  output logic signed [COORD_BITS-1:0] low [cbca_pkg::NUM_AXES],
  output logic signed [COORD_BITS-1:0] high [cbca_pkg::NUM_AXES],
  output logic signed [SUM_W-1:0]      sum [cbca_pkg::NUM_AXES],
  output logic        [CNT_W-1:0]      count
);
  import cbca_pkg::*;

  localparam logic [COORD_BITS-1:0] CMAX    = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] CMIN    = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [CNT_W-1:0]      CNT_LIM = CNT_W'(MAX_POINTS);

  logic signed [COORD_BITS-1:0] low_r [NUM_AXES];
  logic signed [COORD_BITS-1:0] high_r [NUM_AXES];
  logic signed [SUM_W-1:0]      sum_r [NUM_AXES];
  logic        [CNT_W-1:0]      count_r;
  logic                         room;

  assign room = (count_r < CNT_LIM);

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        low_r[a]  <= CMAX;
        high_r[a] <= CMIN;
        sum_r[a]  <= '0;
      end
      count_r <= '0;
    end else if (take) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (pt[a] < low_r[a]) low_r[a] <= pt[a];
        if (pt[a] > high_r[a]) high_r[a] <= pt[a];
        // past the limit only the box keeps growing
        if (room) sum_r[a] <= sum_r[a] + SUM_W'(pt[a]);
      end
      if (room) count_r <= count_r + 1'b1;
    end
  end

  assign low   = low_r;
  assign high  = high_r;
  assign sum   = sum_r;
  assign count = count_r;

endmodule

// ----- rtl/core/cbca_div.sv -----
// shared restoring divider, one quotient bit per cycle, signed dividend,
// quotient truncated toward zero; depends on cbca_pkg
module cbca_div #(
  parameter int DVD_W = 36,
  parameter int DVS_W = 17,
  parameter int Q_W   = cbca_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic        [DVS_W-1:0] divisor,
  output logic                    busy,
  output logic                    done,
  output logic signed [Q_W-1:0]   quotient
);
  import cbca_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  q_r, q_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic              neg_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    diff;
  logic              ge;
  logic [Q_W-1:0]    qmag;

  assign shifted = {rem_r, q_r[DVD_W-1]};
  assign ge      = (shifted >= {1'b0, dvs_r});
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      q_nxt    = {q_r[DVD_W-2:0], ge};
      rem_nxt  = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= STEP_W'(DVD_W);
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= dividend[DVD_W-1];
    end else begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign qmag     = q_r[Q_W-1:0];
  assign quotient = neg_r ? -qmag : qmag;
  assign busy     = busy_r;
  assign done     = done_r;

endmodule

// ----- rtl/core/cbca_ctrl.sv -----
// sequencer: accumulate, then run the shared divider once per axis,
// then hand the result to the output register; depends on cbca_pkg
module cbca_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 last_taken,
  input  logic                 div_done,
  input  logic                 out_free,
  output cbca_pkg::cbca_ctrl_t ctrl
);
  import cbca_pkg::*;

  cbca_state_t state_r, state_nxt;
  cbca_axis_t  axis_r, axis_nxt;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    case (state_r)
      ST_ACC: begin
        if (last_taken) begin
          state_nxt = ST_LAUNCH;
          axis_nxt  = AX_X;
        end
      end
      ST_LAUNCH: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_done) begin
          case (axis_r)
            AX_X: begin
              axis_nxt  = AX_Y;
              state_nxt = ST_LAUNCH;
            end
            AX_Y: begin
              axis_nxt  = AX_Z;
              state_nxt = ST_LAUNCH;
            end
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_ACC;
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_comb begin
    ctrl           = '0;
    ctrl.axis      = axis_r;
    case (state_r)
      ST_ACC:    ctrl.in_ready = 1'b1;
      ST_LAUNCH: ctrl.div_start = 1'b1;
      ST_WAIT:   ctrl.div_start = 1'b0;
      ST_OUT: begin
        ctrl.load_out  = out_free;
        ctrl.acc_clear = out_free;
      end
      default: ctrl.in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      axis_r  <= AX_X;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

// ----- rtl/core/cluster_box_centroid_accumulator.sv -----
// top level of the cluster box / centroid accumulator
// depends on cbca_pkg, cbca_accum, cbca_div, cbca_ctrl
//
// usage: points of one cluster arrive on the in_ channel, one transaction
//   per point, one per cycle while in_tready is high; min, max, sum and count
//   update as they arrive. in_tuser is has_point (0 for a closing transaction
//   without a point) and in_tlast closes the cluster. each closing transaction
//   yields exactly one out_ transaction with box center, size, centroid, floor
//   height and count; out_tuser flags an empty cluster, other fields zero.
// throughput: non-closing points are taken one per cycle. after the
//   closing transaction in_tready drops while one shared serial divider forms
//   the three centroids, one quotient bit per cycle, with SUM_W =
//   COORD_BITS + clog2(MAX_POINTS); the output register is then loaded once free.
// stalls: the result sits in an output register and the block goes on taking
//   points of the next cluster while it waits; a further closing transaction
//   waits in the sequencer, in_tready low, until out_tready frees the register.
// reset: synchronous active-low rst_n empties the accumulators and the output.
// count saturation: beyond MAX_POINTS points the box still grows while sums
//   and count hold.
module cluster_box_centroid_accumulator #(
  parameter int MAX_POINTS = cbca_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cbca_pkg::COORD_BITS_DEF,
  localparam int IN_W  = ((3 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((10 * COORD_BITS + cbca_pkg::COUNT_OUT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // point_x, point_y, point_z
  input  logic [IN_W-1:0]  in_tdata,
  // has_point
  input  logic             in_tuser,
  // last_point
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  // center_x, center_y, center_z, size_x, size_y, size_z,
  // centroid_x, centroid_y, centroid_z, floor_z, point_count, zero fill
  output logic [OUT_W-1:0] out_tdata,
  // no_points
  output logic             out_tuser
);
  import cbca_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = COORD_BITS + $clog2(MAX_POINTS);

  cbca_ctrl_t ctrl;

  logic                take;
  logic                last_taken;
  logic                out_free;
  logic signed [C-1:0] pt [NUM_AXES];
  logic signed [C-1:0] low [NUM_AXES];
  logic signed [C-1:0] high [NUM_AXES];
  logic signed [SUM_W-1:0] sum [NUM_AXES];
  logic [CNT_W-1:0]    count;

  logic signed [SUM_W-1:0] div_dvd;
  logic                div_busy;
  logic                div_done;
  logic signed [C-1:0] div_q;

  // centroid quotients held until the output register is free
  logic signed [C-1:0] cent_r [NUM_AXES];

  logic [OUT_W-1:0] out_tdata_r, out_tdata_nxt;
  logic             out_tuser_r;
  logic             out_tvalid_r;
  logic [C:0]       mid [NUM_AXES];
  logic [C-1:0]     ext [NUM_AXES];
  logic             empty;

  assign in_tready  = ctrl.in_ready;
  assign take       = in_tvalid && ctrl.in_ready && in_tuser;
  assign last_taken = in_tvalid && ctrl.in_ready && in_tlast;
  assign out_free   = !out_tvalid_r || out_tready;

  assign pt[0] = in_tdata[C-1:0];
  assign pt[1] = in_tdata[2*C-1:C];
  assign pt[2] = in_tdata[3*C-1:2*C];

  cbca_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .last_taken (last_taken),
    .div_done   (div_done),
    .out_free   (out_free),
    .ctrl       (ctrl)
  );

  cbca_accum #(
    .COORD_BITS (COORD_BITS),
    .MAX_POINTS (MAX_POINTS),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .clear (ctrl.acc_clear),
    .pt    (pt),
    .low   (low),
    .high  (high),
    .sum   (sum),
    .count (count)
  );

  // the divider's dividend follows the axis the sequencer is on
  always_comb begin
    case (ctrl.axis)
      AX_X:    div_dvd = sum[0];
      AX_Y:    div_dvd = sum[1];
      AX_Z:    div_dvd = sum[2];
      default: div_dvd = sum[0];
    endcase
  end

  cbca_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W),
    .Q_W   (C)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (div_dvd),
    .divisor  (count),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (ctrl.axis)
        AX_X:    cent_r[0] <= div_q;
        AX_Y:    cent_r[1] <= div_q;
        AX_Z:    cent_r[2] <= div_q;
        default: cent_r[0] <= div_q;
      endcase
    end
  end

  // box center is floor((min + max) / 2), one bit wider before the shift
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      mid[a] = {low[a][C-1], low[a]} + {high[a][C-1], high[a]};
      ext[a] = high[a] - low[a];
    end
  end

  assign empty = (count == '0);

  always_comb begin
    out_tdata_nxt = '0;
    if (!empty) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        out_tdata_nxt[a*C +: C]       = mid[a][C:1];
        out_tdata_nxt[(a+3)*C +: C]   = ext[a];
        out_tdata_nxt[(a+6)*C +: C]   = cent_r[a];
      end
      out_tdata_nxt[9*C +: C]           = low[2];
      out_tdata_nxt[10*C +: COUNT_OUT_W] = COUNT_OUT_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= empty;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // a closing transaction hands the block to the divider
  a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    last_taken |=> !in_tready)
    else $error("input still ready after closing transaction");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_out |-> (!out_tvalid_r || out_tready))
    else $error("output register overwritten");

  // the divider is only restarted once idle
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // an empty cluster reports all-zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("empty cluster with nonzero fields");

endmodule
